[sv/sns_pkg.sv]
// shared types, constants and the gaussian decay table for the soft nms block
// used by sns_div, the top level and the checker; depends on nothing
package sns_pkg;

  localparam int unsigned MaxBoxesDef  = 64;
  localparam int unsigned CoordBitsDef = 12;
  localparam logic [15:0] FloorReset   = 16'd655;
  localparam logic [63:0] DecayBaseQ32 = 64'd4294311986;

  typedef struct packed {
    logic [11:0] box_left;
    logic [11:0] box_top;
    logic [11:0] box_right;
    logic [11:0] box_bottom;
    logic [15:0] det_score;
    logic        last_box;
  } box_t;

  typedef struct packed {
    logic [5:0]  pick_index;
    logic [11:0] pick_left;
    logic [11:0] pick_top;
    logic [11:0] pick_right;
    logic [11:0] pick_bottom;
    logic [15:0] pick_score;
    logic        none_picked;
    logic        dropped_boxes;
    logic        last_pick;
  } pick_t;

  typedef struct packed {
    logic       done;
    logic [7:0] ov;
  } div_res_t;

  typedef logic [255:0][15:0] rom_t;

  function automatic logic [63:0] qmul32(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b} + 128'h8000_0000;
    return 64'(p >> 32);
  endfunction

  // entry i is c^(i*i), square and multiply, rounded to q0.16
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] f;
    logic [16:0] n;
    for (int i = 0; i < 256; i++) begin
      n = 17'(i * i);
      r = 64'd1 << 32;
      b = DecayBaseQ32;
      for (int k = 0; k < 17; k++) begin
        if (n[k]) r = qmul32(r, b);
        b = qmul32(b, b);
      end
      f = (r + 64'h8000) >> 16;
      if (f > 64'd65535) f = 64'd65535;
      rom[i] = 16'(f);
    end
    return rom;
  endfunction

  localparam rom_t DecayRom = build_rom();

endpackage

[sv/sns_ram.sv]
// generic single write port ram with one registered read port
// no dependencies
module sns_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/sns_div.sv]
// iterative restoring divider giving floor(num*256/den) saturated to 255, for num <= den
// one quotient bit per cycle; uses sns_pkg::div_res_t
module sns_div #(
  parameter int unsigned DW = 26
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DW-1:0]    num_i,
  input  logic [DW-1:0]    den_i,
  output sns_pkg::div_res_t res_o
);

  logic [DW:0]   rem_q, rem_d, rem_sh;
  logic [DW-1:0] den_q;
  logic [8:0]    quo_q, quo_d;
  logic [3:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d, first_q, first_d, done_q, done_d;
  logic          bit_ge;

  always_comb begin
    rem_sh = first_q ? rem_q : {rem_q[DW-1:0], 1'b0};
    bit_ge = rem_sh >= {1'b0, den_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    first_d = first_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d   = {1'b0, num_i};
      quo_d   = '0;
      cnt_d   = 4'd9;
      busy_d  = 1'b1;
      first_d = 1'b1;
    end else if (busy_q) begin
      rem_d   = bit_ge ? rem_sh - {1'b0, den_q} : rem_sh;
      quo_d   = {quo_q[7:0], bit_ge};
      first_d = 1'b0;
      cnt_d   = cnt_q - 4'd1;
      if (cnt_q == 4'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      first_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign res_o.done = done_q;
  assign res_o.ov   = quo_q[8] ? 8'd255 : quo_q[7:0];

endmodule

[sv/soft_nms_gaussian_overlap.sv]
// top level of the gaussian soft nms block: sequencer, stores and shared multiplier
// depends on sns_pkg, sns_ram and sns_div
//
// Boxes are taken one beat per cycle while in_ready_o is high. The beat with
// last_box set closes the batch and in_ready_o then stays low until the batch's
// last result has been handed to the output register and the clean-up state
// ST_FIN has run. Each selection round scans the loaded boxes through the score
// ram, a read and a compare per box, then runs the pick against every loaded box:
// a box that is skipped or misses leaves early, one that overlaps passes through
// the single shared multiplier (intersection, area, score) and the nine-step
// divider. score_floor may be written at any cycle the block is idle and resets
// to 0.01.
module soft_nms_gaussian_overlap #(
  parameter int unsigned MaxBoxes  = sns_pkg::MaxBoxesDef,
  parameter int unsigned CoordBits = sns_pkg::CoordBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sns_pkg::box_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sns_pkg::pick_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_data_i
);

  localparam int unsigned IW = $clog2(MaxBoxes);
  localparam int unsigned CW = $clog2(MaxBoxes + 1);
  localparam int unsigned CB = CoordBits;
  localparam int unsigned MW = (CB + 1 > 16) ? CB + 1 : 16;
  localparam int unsigned AW = 2 * (CB + 1);
  localparam int unsigned SW = 4 * CB + 16;

  typedef enum logic [4:0] {
    ST_LOAD, ST_SRD, ST_SCMP, ST_SDONE, ST_PRD, ST_PLAT, ST_DRD, ST_DGEO,
    ST_DMUL1, ST_DMUL2, ST_DDIV0, ST_DDIV, ST_DSC, ST_DWR, ST_OUT, ST_FIN
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   cnt_q, kc_q;
  logic [MaxBoxes-1:0] live_q;
  logic            ovf_q, bv_q, pend_v_q, out_last_q, out_valid_q;
  logic [IW-1:0]   best_q;
  logic [15:0]     best_sc_q, floor_q, dec_q;
  logic [CB-1:0]   pk_l_q, pk_t_q, pk_r_q, pk_b_q;
  logic [CB:0]     w_q, h_q, ow_q, oh_q;
  logic [AW-1:0]   inter_q;
  logic [2*MW-1:0] prod_q, prod_d;
  logic [MW-1:0]   mul_a, mul_b;
  sns_pkg::pick_t  pend_q, out_q;
  sns_pkg::pick_t  none_pick, cur_pick, out_next;

  logic            st_we, dc_we;
  logic [IW-1:0]   st_raddr, dc_raddr, dc_waddr;
  logic [SW-1:0]   st_wdata, st_rdata;
  logic [15:0]     dc_wdata, dc_rdata;
  logic [CB-1:0]   o_l, o_t, o_r, o_b, x5, y5, x6, y6;
  logic [15:0]     o_sc;
  logic [2*MW:0]   round_sum;
  logic            div_start;
  sns_pkg::div_res_t div_res;
  logic            accept;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_LOAD);
  assign {o_l, o_t, o_r, o_b, o_sc} = st_rdata;

  assign x5 = (o_l > pk_l_q) ? o_l : pk_l_q;
  assign y5 = (o_t > pk_t_q) ? o_t : pk_t_q;
  assign x6 = (o_r < pk_r_q) ? o_r : pk_r_q;
  assign y6 = (o_b < pk_b_q) ? o_b : pk_b_q;

  assign st_we    = accept && (cnt_q < CW'(MaxBoxes));
  assign st_wdata = {CB'(in_data_i.box_left), CB'(in_data_i.box_top),
                     CB'(in_data_i.box_right), CB'(in_data_i.box_bottom),
                     in_data_i.det_score};
  assign dc_we    = st_we || (state_q == ST_DWR);
  assign dc_waddr = (state_q == ST_DWR) ? kc_q[IW-1:0] : cnt_q[IW-1:0];
  assign round_sum = {1'b0, prod_q} + (2*MW+1)'(32768);
  assign dc_wdata = (state_q == ST_DWR) ? 16'(round_sum >> 16) : in_data_i.det_score;
  assign st_raddr = (state_q == ST_PRD) ? best_q : kc_q[IW-1:0];
  assign dc_raddr = kc_q[IW-1:0];
  assign div_start = (state_q == ST_DDIV0);

  // result beats as they are loaded into the pending and output registers
  always_comb begin
    none_pick             = '0;
    none_pick.none_picked = 1'b1;
    cur_pick              = '0;
    cur_pick.pick_index   = 6'(best_q);
    cur_pick.pick_left    = 12'(o_l);
    cur_pick.pick_top     = 12'(o_t);
    cur_pick.pick_right   = 12'(o_r);
    cur_pick.pick_bottom  = 12'(o_b);
    cur_pick.pick_score   = o_sc;
    out_next               = pend_q;
    out_next.dropped_boxes = ovf_q;
    out_next.last_pick     = out_last_q;
  end

  // one multiplier, operands chosen by the step
  always_comb begin
    case (state_q)
      ST_DMUL1: begin
        mul_a = MW'(w_q);
        mul_b = MW'(h_q);
      end
      ST_DMUL2: begin
        mul_a = MW'(ow_q);
        mul_b = MW'(oh_q);
      end
      default: begin
        mul_a = MW'(dec_q);
        mul_b = MW'(sns_pkg::DecayRom[div_res.ov]);
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  sns_ram #(.Width(SW), .Depth(MaxBoxes)) u_static_ram (
    .clk_i, .we_i(st_we), .waddr_i(cnt_q[IW-1:0]), .wdata_i(st_wdata),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

  sns_ram #(.Width(16), .Depth(MaxBoxes)) u_score_ram (
    .clk_i, .we_i(dc_we), .waddr_i(dc_waddr), .wdata_i(dc_wdata),
    .raddr_i(dc_raddr), .rdata_o(dc_rdata)
  );

  sns_div #(.DW(AW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(inter_q),
    .den_i(AW'(prod_q)), .res_o(div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      kc_q        <= '0;
      live_q      <= '0;
      ovf_q       <= 1'b0;
      bv_q        <= 1'b0;
      pend_v_q    <= 1'b0;
      out_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
      floor_q     <= sns_pkg::FloorReset;
      best_q      <= '0;
      best_sc_q   <= '0;
      dec_q       <= '0;
      pk_l_q      <= '0;
      pk_t_q      <= '0;
      pk_r_q      <= '0;
      pk_b_q      <= '0;
      w_q         <= '0;
      h_q         <= '0;
      ow_q        <= '0;
      oh_q        <= '0;
      inter_q     <= '0;
      prod_q      <= '0;
      pend_q      <= '0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) floor_q <= cfg_data_i;
      if (out_valid_q && out_ready_i && state_q != ST_OUT) out_valid_q <= 1'b0;
      case (state_q)
        ST_LOAD: begin
          if (accept) begin
            if (st_we) begin
              live_q[cnt_q[IW-1:0]] <= 1'b1;
              cnt_q <= cnt_q + CW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (in_data_i.last_box) begin
              kc_q    <= '0;
              bv_q    <= 1'b0;
              state_q <= ST_SRD;
            end
          end
        end
        ST_SRD: begin
          state_q <= (kc_q == cnt_q) ? ST_SDONE : ST_SCMP;
        end
        ST_SCMP: begin
          // strict compare keeps the lowest index on a tie
          if (live_q[kc_q[IW-1:0]] && (!bv_q || dc_rdata > best_sc_q)) begin
            bv_q      <= 1'b1;
            best_q    <= kc_q[IW-1:0];
            best_sc_q <= dc_rdata;
          end
          kc_q    <= kc_q + CW'(1);
          state_q <= ST_SRD;
        end
        ST_SDONE: begin
          if (bv_q && best_sc_q >= floor_q) begin
            out_last_q <= 1'b0;
            state_q    <= pend_v_q ? ST_OUT : ST_PRD;
          end else begin
            out_last_q <= 1'b1;
            if (!pend_v_q) pend_q <= none_pick;
            state_q <= ST_OUT;
          end
        end
        ST_PRD: begin
          state_q <= ST_PLAT;
        end
        ST_PLAT: begin
          pk_l_q         <= o_l;
          pk_t_q         <= o_t;
          pk_r_q         <= o_r;
          pk_b_q         <= o_b;
          pend_q         <= cur_pick;
          pend_v_q       <= 1'b1;
          live_q[best_q] <= 1'b0;
          kc_q           <= '0;
          state_q        <= ST_DRD;
        end
        ST_DRD: begin
          if (kc_q == cnt_q) begin
            kc_q    <= '0;
            bv_q    <= 1'b0;
            state_q <= ST_SRD;
          end else if (!live_q[kc_q[IW-1:0]]) begin
            kc_q <= kc_q + CW'(1);
          end else begin
            state_q <= ST_DGEO;
          end
        end
        ST_DGEO: begin
          dec_q <= dc_rdata;
          w_q   <= {1'b0, x6} - {1'b0, x5} + (CB+1)'(1);
          h_q   <= {1'b0, y6} - {1'b0, y5} + (CB+1)'(1);
          ow_q  <= {1'b0, o_r} - {1'b0, o_l} + (CB+1)'(1);
          oh_q  <= {1'b0, o_b} - {1'b0, o_t} + (CB+1)'(1);
          if (x6 < x5 || y6 < y5) begin
            kc_q    <= kc_q + CW'(1);
            state_q <= ST_DRD;
          end else begin
            state_q <= ST_DMUL1;
          end
        end
        ST_DMUL1: begin
          prod_q  <= prod_d;
          state_q <= ST_DMUL2;
        end
        ST_DMUL2: begin
          inter_q <= AW'(prod_q);
          prod_q  <= prod_d;
          state_q <= ST_DDIV0;
        end
        ST_DDIV0: begin
          state_q <= ST_DDIV;
        end
        ST_DDIV: begin
          if (div_res.done) state_q <= ST_DSC;
        end
        ST_DSC: begin
          prod_q  <= prod_d;
          state_q <= ST_DWR;
        end
        ST_DWR: begin
          kc_q    <= kc_q + CW'(1);
          state_q <= ST_DRD;
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_q       <= out_next;
            state_q     <= out_last_q ? ST_FIN : ST_PRD;
          end
        end
        ST_FIN: begin
          live_q   <= '0;
          cnt_q    <= '0;
          ovf_q    <= 1'b0;
          pend_v_q <= 1'b0;
          state_q  <= ST_LOAD;
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sv/sns_checker.sv]
// port level checks for soft_nms_gaussian_overlap, bound to the top level
// depends on sns_pkg and the top level's ports
module sns_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input sns_pkg::box_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input sns_pkg::pick_t out_data_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.none_picked |-> out_data_o.last_pick)
    else $error("none_picked result not marked last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.none_picked |->
      out_data_o.pick_score == 16'd0 && out_data_o.pick_index == 6'd0)
    else $error("none_picked result carries data");

  // closing beat starts selection, input side goes quiet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last_box |=> !in_ready_o)
    else $error("input taken during selection");

endmodule

bind soft_nms_gaussian_overlap sns_checker u_sns_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
  .out_valid_o, .out_ready_i, .out_data_o
);
